FILE: rtl/rect_occupancy_table_macros.svh
// Assertion macros for the rectangle occupancy table checker
`ifndef RECT_OCCUPANCY_TABLE_MACROS_SVH
`define RECT_OCCUPANCY_TABLE_MACROS_SVH
`define ROT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ROT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: rtl/rot_pkg.sv
// Package: constants, types and helpers for the rectangle occupancy table
package rot_pkg;
	localparam int TableDepth = 64;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam int CoordW = 13;

	typedef enum logic [2:0] {
		ACT_PLACE = 3'd0,
		ACT_REMOVE = 3'd1,
		ACT_POINT = 3'd2,
		ACT_AREA = 3'd3,
		ACT_BUILD = 3'd4
	} action_t;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [0:0] REG_HALF_EXTENT = 1'd0;
	localparam logic [0:0] REG_MARGIN = 1'd1;

	typedef struct packed {
		logic signed [CoordW-1:0] left;
		logic signed [CoordW-1:0] top;
		logic signed [CoordW-1:0] right;
		logic signed [CoordW-1:0] bottom;
	} rect_t;

	typedef struct packed {
		logic [15:0] id;
		rect_t bounds;
	} entry_t;

	// broadcast from controller to cells
	typedef struct packed {
		logic shift_up;      // cells at or past del_idx take their neighbor's entry
		logic write;         // cell wr_idx loads wr_entry
		logic [IdxW-1:0] wr_idx;
		logic [IdxW-1:0] del_idx;
		entry_t wr_entry;
		rect_t area;
		logic signed [CoordW-1:0] pt_x;   // point query uses corner a as given
		logic signed [CoordW-1:0] pt_y;
		logic [15:0] id;
	} cell_ctl_t;

	typedef struct packed {
		logic id_eq;
		logic pt_hit;
		logic area_hit;
	} cell_flags_t;

	// round half away from zero to a field coordinate
	function automatic logic signed [CoordW-1:0] to_field(input logic signed [15:0] v);
		logic [15:0] mag;
		logic [16:0] sum;
		logic [CoordW-1:0] f;
		mag = v[15] ? 16'(-v) : 16'(v);
		sum = {1'b0, mag} + 17'd8;
		f = CoordW'(sum[16:4]);
		return v[15] ? CoordW'(-f) : f;
	endfunction
endpackage

FILE: rtl/rot_if.sv
// Valid/ready channel carrying a typed payload
interface rot_if #(type payload_t = logic) (input logic clk);
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/rot_cell.sv
// One table slot: holds an entry, shifts up on remove, compares against the request
module rot_cell (
	input logic clk,
	input rot_pkg::cell_ctl_t ctl,
	input logic [rot_pkg::IdxW-1:0] my_idx,
	input rot_pkg::entry_t nbr_entry,
	input logic [1:0] pt_sel,
	output rot_pkg::entry_t entry,
	output rot_pkg::cell_flags_t flags
);
	import rot_pkg::*;
	entry_t entry_q;
	rect_t e;
	rect_t a;
	logic inter;
	logic cont;

	always_ff @(posedge clk) begin
		if (ctl.write && ctl.wr_idx == my_idx) begin
			entry_q <= ctl.wr_entry;
		end else if (ctl.shift_up && my_idx >= ctl.del_idx) begin
			entry_q <= nbr_entry;
		end
	end

	assign entry = entry_q;
	assign e = entry_q.bounds;
	assign a = ctl.area;
	assign inter = a.left < e.right && e.left < a.right && a.top < e.bottom && e.top < a.bottom;
	assign cont = e.left <= a.left && a.right <= e.right && e.top <= a.top && a.bottom <= e.bottom;

	always_comb begin
		flags.id_eq = entry_q.id == ctl.id;
		flags.area_hit = inter || cont;
		flags.pt_hit = e.left <= ctl.pt_x && ctl.pt_x < e.right
			&& e.top <= ctl.pt_y && ctl.pt_y < e.bottom
			&& pt_sel == 2'd0;
	end
endmodule

FILE: rtl/rect_occupancy_table.sv
// Top level: request decode, cell chain, hit scan and result register
// Result registered in S_EVAL, after request accept; area query hits follow from S_SCAN.
// Area query emits one hit per cycle unless stalled; walks the 64-entry hit mask by priority.
// Other actions give one result; next request taken the cycle after the last result is taken.
// Reset clears the entry count, state and response registers; entry contents stay undefined.
module rect_occupancy_table (
	input logic clk,
	input logic arst_n,
	rot_if.sink req,
	rot_if.source rsp,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [10:0] cfg_data
);
	import rot_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_EVAL, S_SCAN, S_OUT} state_t;

	state_t state_q;
	logic [10:0] half_q;
	logic [3:0] margin_q;
	logic [CntW-1:0] count_q;
	action_t act_s1;
	logic [15:0] id_s1;
	rect_t area_s1;
	logic signed [CoordW-1:0] pt_x_s1;
	logic signed [CoordW-1:0] pt_y_s1;
	logic [TableDepth-1:0] mask_q;
	logic bc_ok_q;
	logic any_q;
	logic rsp_valid_q;
	logic [15:0] rsp_unit_q;
	logic rsp_hit_q;
	logic rsp_allowed_q;
	logic [1:0] rsp_status_q;
	logic rsp_last_q;

	cell_ctl_t ctl;
	entry_t entries [TableDepth];
	cell_flags_t flags [TableDepth];
	logic [TableDepth-1:0] valid_v, id_v, pt_v, area_v;

	genvar g;
	generate
		for (g = 0; g < TableDepth; g++) begin : g_cell
			rot_cell u_cell (
				.clk(clk),
				.ctl(ctl),
				.my_idx(IdxW'(g)),
				.nbr_entry(entries[(g + 1) % TableDepth]),
				.pt_sel(2'd0),
				.entry(entries[g]),
				.flags(flags[g])
			);
			assign valid_v[g] = CntW'(g) < count_q;
			assign id_v[g] = flags[g].id_eq && valid_v[g];
			assign pt_v[g] = flags[g].pt_hit && valid_v[g];
			assign area_v[g] = flags[g].area_hit && valid_v[g];
		end
	endgenerate

	function automatic logic [IdxW-1:0] first_idx(input logic [TableDepth-1:0] v);
		logic [IdxW-1:0] r;
		r = '0;
		for (int i = TableDepth - 1; i >= 0; i--) begin
			if (v[i]) r = IdxW'(i);
		end
		return r;
	endfunction

	logic [IdxW-1:0] id_pos, pt_pos, sc_pos;
	logic [TableDepth-1:0] mask_rest;
	assign id_pos = first_idx(id_v);
	assign pt_pos = first_idx(pt_v);
	assign sc_pos = first_idx(mask_q);
	assign mask_rest = mask_q & ~(TableDepth'(1) << sc_pos);

	logic signed [CoordW-1:0] fax, fay, fbx, fby;
	assign fax = to_field(req.data.corner_a_x);
	assign fay = to_field(req.data.corner_a_y);
	assign fbx = to_field(req.data.corner_b_x);
	assign fby = to_field(req.data.corner_b_y);

	logic signed [CoordW-1:0] m_s, h_s;
	assign m_s = CoordW'(margin_q);
	assign h_s = CoordW'(half_q);

	logic eval_place, eval_remove, found, full;
	assign found = |id_v;
	assign full = count_q >= CntW'(TableDepth);
	assign eval_place = state_q == S_EVAL && act_s1 == ACT_PLACE;
	assign eval_remove = state_q == S_EVAL && act_s1 == ACT_REMOVE;

	always_comb begin
		ctl.area = area_s1;
		ctl.pt_x = pt_x_s1;
		ctl.pt_y = pt_y_s1;
		ctl.id = id_s1;
		ctl.del_idx = id_pos;
		ctl.shift_up = eval_remove && found;
		ctl.write = eval_place && (found || !full);
		ctl.wr_idx = found ? id_pos : IdxW'(count_q);
		ctl.wr_entry.id = id_s1;
		ctl.wr_entry.bounds.left = area_s1.left - m_s;
		ctl.wr_entry.bounds.top = area_s1.top - m_s;
		ctl.wr_entry.bounds.right = area_s1.right + m_s;
		ctl.wr_entry.bounds.bottom = area_s1.bottom + m_s;
	end

	logic area_one, area_own, out_ok;
	assign area_one = $countones(area_v) == 1;
	assign area_own = area_one && entries[first_idx(area_v)].id == id_s1;
	assign out_ok = !(area_s1.left < -h_s || area_s1.right > h_s
		|| area_s1.top < -h_s || area_s1.bottom > h_s);

	assign req.ready = state_q == S_IDLE;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data.hit_unit = rsp_unit_q;
	assign rsp.data.hit = rsp_hit_q;
	assign rsp.data.allowed = rsp_allowed_q;
	assign rsp.data.status = rsp_status_q;
	assign rsp.data.last = rsp_last_q;

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			id_s1 <= req.data.unit_id;
			pt_x_s1 <= fax;
			pt_y_s1 <= fay;
			area_s1.left <= fax < fbx ? fax : fbx;
			area_s1.right <= fax < fbx ? fbx : fax;
			area_s1.top <= fay < fby ? fay : fby;
			area_s1.bottom <= fay < fby ? fby : fay;
		end
		if (state_q == S_EVAL) begin
			mask_q <= area_v;
		end else if (state_q == S_SCAN && (!rsp_valid_q || rsp.ready)) begin
			mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			half_q <= 11'd1024;
			margin_q <= 4'd1;
			count_q <= '0;
			act_s1 <= ACT_PLACE;
			rsp_valid_q <= 1'b0;
			rsp_unit_q <= '0;
			rsp_hit_q <= 1'b0;
			rsp_allowed_q <= 1'b0;
			rsp_status_q <= ST_DONE;
			rsp_last_q <= 1'b0;
			bc_ok_q <= 1'b0;
			any_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HALF_EXTENT: half_q <= cfg_data;
					REG_MARGIN: margin_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						act_s1 <= action_t'(req.data.action);
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					rsp_valid_q <= 1'b1;
					rsp_unit_q <= '0;
					rsp_hit_q <= 1'b0;
					rsp_allowed_q <= 1'b0;
					rsp_status_q <= ST_DONE;
					rsp_last_q <= 1'b1;
					state_q <= S_OUT;
					unique case (act_s1)
						ACT_PLACE: begin
							if (!found && full) rsp_status_q <= ST_FULL;
							else if (!found) count_q <= count_q + 1'b1;
						end
						ACT_REMOVE: begin
							if (!found) rsp_status_q <= ST_NOT_FOUND;
							else count_q <= count_q - 1'b1;
						end
						ACT_POINT: begin
							if (|pt_v) begin
								rsp_hit_q <= 1'b1;
								rsp_unit_q <= entries[pt_pos].id;
							end
						end
						ACT_AREA: begin
							if (|area_v) begin
								rsp_valid_q <= 1'b0;
								state_q <= S_SCAN;
							end
						end
						ACT_BUILD: rsp_allowed_q <= out_ok && (!(|area_v) || area_own);
						default: ;
					endcase
				end
				S_SCAN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_hit_q <= 1'b1;
						rsp_unit_q <= entries[sc_pos].id;
						rsp_last_q <= !(|mask_rest);
						if (!(|mask_rest)) state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/rot_checker.sv
// Port-level checker for the rectangle occupancy table, bound to the top level
`include "rect_occupancy_table_macros.svh"
module rot_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_hit,
	input logic rsp_allowed,
	input logic [1:0] rsp_status,
	input logic rsp_last
);
	import rot_pkg::*;
	`ROT_ASSERT_NXT(a_no_req_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)
	`ROT_ASSERT_IMP(a_hit_no_allow, clk, arst_n, rsp_valid && rsp_hit, !rsp_allowed)
	`ROT_ASSERT_IMP(a_bad_status_last, clk, arst_n, rsp_valid && rsp_status != ST_DONE, rsp_last && !rsp_hit)
	`ROT_ASSERT_IMP(a_busy_on_rsp, clk, arst_n, rsp_valid, !req_ready)
endmodule

bind rect_occupancy_table rot_checker u_rot_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_hit(rsp.data.hit),
	.rsp_allowed(rsp.data.allowed),
	.rsp_status(rsp.data.status),
	.rsp_last(rsp.data.last)
);
